// File: src/mtnp_pkg.sv
package mtnp_pkg;

    localparam int TICK_W  = 32;
    localparam int TPB_W   = 16;
    localparam int SCALE_W = 39;            // tick * 120 fits in 39 bits
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    // parse phases
    localparam logic [3:0] PH_HDR    = 4'd0;
    localparam logic [3:0] PH_NTRK   = 4'd1;
    localparam logic [3:0] PH_TBASE  = 4'd2;
    localparam logic [3:0] PH_TAG    = 4'd3;
    localparam logic [3:0] PH_LEN    = 4'd4;
    localparam logic [3:0] PH_DELTA  = 4'd5;
    localparam logic [3:0] PH_STATUS = 4'd6;
    localparam logic [3:0] PH_KEY    = 4'd7;
    localparam logic [3:0] PH_VEL    = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;

    localparam logic [3:0] KIND_OFF = 4'h8;
    localparam logic [3:0] KIND_ON  = 4'h9;

    localparam logic REC_START = 1'b0;
    localparam logic REC_END   = 1'b1;

    // command from the parser to the note unit
    typedef struct packed {
        logic              clear;
        logic              note_on;
        logic [3:0]        channel;
        logic [6:0]        key;
        logic [6:0]        velocity;
        logic [TICK_W-1:0] tick;
        logic [TPB_W-1:0]  tpb;
    } t_cmd;

    typedef struct packed {
        logic [15:0] note_index;
        logic [31:0] position;
        logic [31:0] interval;
        logic [3:0]  channel;
        logic [6:0]  note_key;
        logic [6:0]  velocity;
        logic [31:0] note_length;
    } t_rec;

endpackage

// File: src/mtnp_front.sv
module mtnp_front #(
    parameter int CHANNELS = 16,
    parameter int KEYS     = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_sof,
    input  logic [7:0]     i_byte,
    output logic           o_push,
    output mtnp_pkg::t_cmd o_cmd
);
    import mtnp_pkg::*;

    logic [3:0]        r_phase, n_phase;
    logic [3:0]        r_cnt, n_cnt;
    logic [15:0]       r_tracks, n_tracks;
    logic [TPB_W-1:0]  r_tpb, n_tpb;
    logic [31:0]       r_tbl, n_tbl;
    logic [27:0]       r_delta, n_delta;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [7:0]        r_status, n_status;
    logic [6:0]        r_key, n_key;

    always_comb begin
        logic [3:0]  cnt_inc;
        logic [15:0] trk_dec;
        logic        evt_ok;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_tracks = r_tracks;
        n_tpb    = r_tpb;
        n_tbl    = r_tbl;
        n_delta  = r_delta;
        n_tick   = r_tick;
        n_status = r_status;
        n_key    = r_key;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (i_sof) begin
            n_phase = PH_HDR; n_cnt = '0; n_tracks = '0; n_tpb = '0; n_tbl = '0;
            n_delta = '0; n_tick = '0; n_status = '0; n_key = '0;
            o_push = i_accept;
            o_cmd.clear = 1'b1;
        end
        cnt_inc = n_cnt + 4'd1;
        trk_dec = n_tracks - 16'd1;
        evt_ok  = ((n_status[7:4] == KIND_ON) || (n_status[7:4] == KIND_OFF))
                  && ({28'd0, n_status[3:0]} < CHANNELS) && ({25'd0, n_key} < KEYS);
        case (n_phase)
            PH_HDR: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'd10) begin
                    n_cnt = '0; n_phase = PH_NTRK;
                end
            end
            PH_NTRK: begin
                n_tracks = {n_tracks[7:0], i_byte};
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'd2) begin
                    n_cnt = '0; n_phase = PH_TBASE;
                end
            end
            PH_TBASE: begin
                n_tpb = {n_tpb[7:0], i_byte};
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'd2) begin
                    n_cnt = '0;
                    n_phase = (n_tracks == '0) ? PH_DONE : PH_TAG;
                end
            end
            PH_TAG: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'd4) begin
                    n_cnt = '0; n_tbl = '0; n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_tbl = {n_tbl[23:0], i_byte};
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'd4) begin
                    n_cnt = '0; n_delta = '0;
                    if ({n_tbl[23:0], i_byte} == '0) begin
                        n_tracks = trk_dec;
                        n_phase  = (trk_dec == '0) ? PH_DONE : PH_TAG;
                    end else begin
                        n_phase = PH_DELTA;
                    end
                end
            end
            PH_DELTA: begin
                if (n_tbl != '0) n_tbl = n_tbl - 32'd1;
                n_delta = {n_delta[20:0], i_byte[6:0]};
                n_cnt = cnt_inc;
                if (!i_byte[7] || cnt_inc >= 4'd4) begin
                    n_tick  = n_tick + {4'd0, n_delta};
                    n_delta = '0; n_cnt = '0; n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (n_tbl != '0) n_tbl = n_tbl - 32'd1;
                n_status = i_byte;
                n_phase  = PH_KEY;
            end
            PH_KEY: begin
                if (n_tbl != '0) n_tbl = n_tbl - 32'd1;
                n_key   = i_byte[6:0];
                n_phase = PH_VEL;
            end
            PH_VEL: begin
                if (n_tbl != '0) n_tbl = n_tbl - 32'd1;
                o_push           = i_accept && evt_ok;
                o_cmd.note_on    = (n_status[7:4] == KIND_ON);
                o_cmd.channel    = n_status[3:0];
                o_cmd.key        = n_key;
                o_cmd.velocity   = i_byte[6:0];
                o_cmd.tick       = n_tick;
                o_cmd.tpb        = n_tpb;
                n_cnt = '0; n_delta = '0;
                if (n_tbl == '0) begin
                    n_tracks = trk_dec;
                    n_phase  = (trk_dec == '0) ? PH_DONE : PH_TAG;
                end else begin
                    n_phase = PH_DELTA;
                end
            end
            default: n_phase = PH_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_cnt <= '0; r_tracks <= '0; r_tpb <= '0; r_tbl <= '0;
            r_delta <= '0; r_tick <= '0; r_status <= '0; r_key <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_tracks <= n_tracks; r_tpb <= n_tpb;
            r_tbl <= n_tbl; r_delta <= n_delta; r_tick <= n_tick;
            r_status <= n_status; r_key <= n_key;
        end
    end

endmodule

// File: src/mtnp_fifo.sv
module mtnp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtnp_pkg::t_cmd i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output mtnp_pkg::t_cmd o_data
);
    import mtnp_pkg::*;

    t_cmd            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: src/mtnp_back.sv
module mtnp_back #(
    parameter int CHANNELS        = 16,
    parameter int KEYS            = 128,
    parameter int NOTE_INDEX_BITS = 16,
    parameter int POSITION_BITS   = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mtnp_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output mtnp_pkg::t_rec o_rec
);
    import mtnp_pkg::*;

    localparam int DEPTH = CHANNELS * KEYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NIB   = NOTE_INDEX_BITS;
    localparam int PB    = POSITION_BITS;
    localparam int EW    = 1 + NIB + PB;
    localparam int DCW   = $clog2(SCALE_W + 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]         r_state;
    logic [AW-1:0]      r_addr;
    logic [EW-1:0]      r_mem [DEPTH];
    logic [EW-1:0]      r_rd;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [EW-1:0]      mem_wd;
    logic [NIB-1:0]     r_counter;
    logic [PB-1:0]      r_last;
    t_cmd               r_cmd;
    logic [SCALE_W-1:0] r_quo;
    logic [TPB_W:0]     r_rem;
    logic [DCW-1:0]     r_dcnt;
    logic               r_out_valid;
    logic               r_out_kind;
    t_rec               r_out;

    // stored entry fields
    logic               e_valid;
    logic [NIB-1:0]     e_index;
    logic [PB-1:0]      e_start;
    assign e_valid = r_rd[EW-1];
    assign e_index = r_rd[EW-2 -: NIB];
    assign e_start = r_rd[PB-1:0];

    logic [SCALE_W-1:0] dividend;
    logic [12:0]        addr_full;
    logic [TPB_W:0]     rem_sh;
    logic [TPB_W:0]     rem_sub;
    logic [PB-1:0]      pos;
    logic [NIB-1:0]     cnt_inc;
    logic               slot_free;
    logic               emit_rec;
    logic [SCALE_W+PB-1:0] q_ext;

    assign dividend  = {i_cmd.tick, 7'd0} - {4'd0, i_cmd.tick, 3'd0};
    assign addr_full = 13'(i_cmd.channel) * 13'(KEYS) + 13'(i_cmd.key);
    assign rem_sh    = {r_rem[TPB_W-1:0], r_quo[SCALE_W-1]};
    assign rem_sub   = rem_sh - {1'b0, r_cmd.tpb};
    assign q_ext     = {{PB{1'b0}}, r_quo};
    assign pos       = (r_cmd.tpb == '0) ? '0 : q_ext[PB-1:0];
    assign cnt_inc   = (r_counter + 1'b1 == '0) ? NIB'(1) : r_counter + 1'b1;
    assign slot_free = !r_out_valid || i_ready;
    assign emit_rec  = (r_state == S_EMIT) && slot_free && (r_cmd.note_on || e_valid);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    function automatic logic [31:0] to32(input logic [PB-1:0] v);
        logic [PB+31:0] e;
        e = {32'd0, v};
        return e[31:0];
    endfunction

    function automatic logic [15:0] to16(input logic [NIB-1:0] v);
        logic [NIB+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
        end else if (r_state == S_EMIT && slot_free) begin
            if (r_cmd.note_on) begin
                mem_we = 1'b1;
                mem_wd = {1'b1, cnt_inc, pos};
            end else if (e_valid) begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_counter   <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_rec) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_counter <= '0;
                    r_last    <= '0;
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_addr <= r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.clear) begin
                            r_addr  <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_addr  <= addr_full[AW-1:0];
                            r_quo   <= dividend;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_cmd.tpb}) begin
                        r_rem <= rem_sub;
                        r_quo <= {r_quo[SCALE_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[SCALE_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(SCALE_W - 1)) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                        r_out.channel  <= r_cmd.channel;
                        r_out.note_key <= r_cmd.key;
                        if (r_cmd.note_on) begin
                            r_counter         <= cnt_inc;
                            r_last            <= pos;
                            r_out_kind        <= REC_START;
                            r_out.note_index  <= to16(cnt_inc);
                            r_out.position    <= to32(pos);
                            r_out.interval    <= to32(pos - r_last);
                            r_out.velocity    <= r_cmd.velocity;
                            r_out.note_length <= '0;
                        end else if (e_valid) begin
                            r_out_kind        <= REC_END;
                            r_out.note_index  <= to16(e_index);
                            r_out.position    <= to32(e_start);
                            r_out.interval    <= '0;
                            r_out.velocity    <= '0;
                            r_out.note_length <= to32(pos - e_start);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_rec   = r_out;

endmodule

// File: src/midi_track_note_parser_core.sv
// channel  | direction | tvalid/tready                  | tdata / tuser
// s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | tdata: data_byte; tuser: start_of_file
// m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | tdata: note record; tuser: record_kind
//
// one file byte is taken per cycle while the command queue has room
// a note event passes through the note unit in order: the command is taken,
// 39 scale divider steps run, then the record is written (held back while a record waits)
// after reset, and on every start_of_file, the pending-note memory is cleared one
// entry a cycle, all CHANNELS*KEYS entries (2048 by default), before the next note event
// the output register lets the note unit divide the next command while a record waits to be taken
module midi_track_note_parser_core #(
    parameter int CHANNELS        = 16,
    parameter int KEYS            = 128,
    parameter int NOTE_INDEX_BITS = 16,
    parameter int POSITION_BITS   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tuser,   // [0] start_of_file
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] note_index, [47:16] position, [79:48] interval, [83:80] channel,
    // [90:84] note_key, [97:91] velocity, [129:98] note_length, [135:130] zero
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // [0] record_kind
);
    import mtnp_pkg::*;

    logic accept;
    logic push, pop, full, empty;
    t_cmd cmd_in, cmd_out;
    t_rec rec;

    // a byte is only taken when the queue can hold the command it may raise
    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    mtnp_front #(.CHANNELS(CHANNELS), .KEYS(KEYS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_sof   (i_s_axis_tuser),
        .i_byte  (i_s_axis_tdata),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    mtnp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cmd_in),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_data (cmd_out)
    );

    mtnp_back #(
        .CHANNELS(CHANNELS), .KEYS(KEYS),
        .NOTE_INDEX_BITS(NOTE_INDEX_BITS), .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_cmd  (cmd_out),
        .o_pop  (pop),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_kind (o_m_axis_tuser),
        .o_rec  (rec)
    );

    assign o_m_axis_tdata = {6'd0, rec.note_length, rec.velocity, rec.note_key,
                             rec.channel, rec.interval, rec.position, rec.note_index};

endmodule

// File: sim/mtnp_scoreboard.sv
`timescale 1ns / 1ps

// watches both channels of the note parser, predicts its records and compares them
module mtnp_scoreboard (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,
    input  logic         i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [135:0] i_m_axis_tdata,
    input  logic         i_m_axis_tuser,
    output int           o_fail_count,
    output int           o_records_due
);
    import mtnp_pkg::*;

    typedef struct {
        logic        kind;
        logic [15:0] note_index;
        logic [31:0] position;
        logic [31:0] interval;
        logic [3:0]  channel;
        logic [6:0]  note_key;
        logic [6:0]  velocity;
        logic [31:0] note_length;
    } t_note_rec;

    t_note_rec   due_records[$];

    // mirror of the parser state
    logic [3:0]  phase;
    int          byte_cnt;
    logic [15:0] tracks_left;
    logic [15:0] tpb;
    logic [31:0] track_left;
    logic [27:0] delta_acc;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [6:0]  key;
    logic [15:0] note_cnt;
    logic [31:0] last_start;
    bit          held_valid [2048];
    logic [15:0] held_index [2048];
    logic [31:0] held_start [2048];

    function automatic void clear_parser();
        phase = PH_HDR;
        byte_cnt = 0;
        tracks_left = '0;
        tpb = '0;
        track_left = '0;
        delta_acc = '0;
        tick = '0;
        status = '0;
        key = '0;
        note_cnt = '0;
        last_start = '0;
        for (int i = 0; i < 2048; i++) held_valid[i] = 1'b0;
    endfunction

    function automatic logic [31:0] scaled_pos();
        logic [63:0] prod;
        if (tpb == 0) return '0;
        prod = 64'(tick) * 64'd120 / 64'(tpb);
        return prod[31:0];
    endfunction

    function automatic void end_track();
        tracks_left = tracks_left - 16'd1;
        byte_cnt = 0;
        phase = (tracks_left == 0) ? PH_DONE : PH_TAG;
    endfunction

    function automatic void event_done();
        byte_cnt = 0;
        delta_acc = '0;
        if (track_left == 0) end_track();
        else phase = PH_DELTA;
    endfunction

    // note event completes on the velocity byte
    function automatic void note_event(logic [7:0] vel);
        logic [3:0]  ch;
        int          slot;
        logic [31:0] p;
        t_note_rec   r;
        ch = status[3:0];
        slot = int'(ch) * 128 + int'(key);
        p = scaled_pos();
        if (status[7:4] == KIND_ON) begin
            note_cnt = note_cnt + 16'd1;
            if (note_cnt == 0) note_cnt = 16'd1;
            held_valid[slot] = 1'b1;
            held_index[slot] = note_cnt;
            held_start[slot] = p;
            r = '{REC_START, note_cnt, p, p - last_start, ch, key, vel[6:0], 32'd0};
            due_records.push_back(r);
            last_start = p;
        end else if (status[7:4] == KIND_OFF && held_valid[slot]) begin
            r = '{REC_END, held_index[slot], held_start[slot], 32'd0, ch, key, 7'd0,
                  p - held_start[slot]};
            due_records.push_back(r);
            held_valid[slot] = 1'b0;
        end
    endfunction

    function automatic void take_byte(logic sof, logic [7:0] b);
        if (sof) clear_parser();
        if (phase >= PH_DELTA && phase <= PH_VEL && track_left != 0)
            track_left = track_left - 32'd1;
        case (phase)
            PH_HDR: begin
                byte_cnt++;
                if (byte_cnt >= 10) begin
                    byte_cnt = 0;
                    phase = PH_NTRK;
                end
            end
            PH_NTRK: begin
                tracks_left = {tracks_left[7:0], b};
                byte_cnt++;
                if (byte_cnt >= 2) begin
                    byte_cnt = 0;
                    phase = PH_TBASE;
                end
            end
            PH_TBASE: begin
                tpb = {tpb[7:0], b};
                byte_cnt++;
                if (byte_cnt >= 2) begin
                    byte_cnt = 0;
                    phase = (tracks_left == 0) ? PH_DONE : PH_TAG;
                end
            end
            PH_TAG: begin
                byte_cnt++;
                if (byte_cnt >= 4) begin
                    byte_cnt = 0;
                    track_left = '0;
                    phase = PH_LEN;
                end
            end
            PH_LEN: begin
                track_left = {track_left[23:0], b};
                byte_cnt++;
                if (byte_cnt >= 4) event_done();
            end
            PH_DELTA: begin
                delta_acc = {delta_acc[20:0], b[6:0]};
                byte_cnt++;
                // a delta stops after its fourth byte regardless of bit 7
                if (!b[7] || byte_cnt >= 4) begin
                    tick = tick + 32'(delta_acc);
                    delta_acc = '0;
                    byte_cnt = 0;
                    phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                status = b;
                phase = PH_KEY;
            end
            PH_KEY: begin
                key = b[6:0];
                phase = PH_VEL;
            end
            PH_VEL: begin
                note_event(b);
                event_done();
            end
            default: phase = PH_DONE;
        endcase
    endfunction

    function automatic int field_ok(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0h, actual %0h", name, e, a);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_note_rec e;
        int        bad;
        if (!i_rst_n) begin
            clear_parser();
            due_records.delete();
            o_fail_count <= 0;
        end else begin
            bad = 0;
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (due_records.size() == 0) begin
                    $error("record transfer with nothing expected");
                    bad = 1;
                end else begin
                    e = due_records.pop_front();
                    bad += field_ok("record_kind", e.kind, i_m_axis_tuser);
                    bad += field_ok("note_index", e.note_index, i_m_axis_tdata[15:0]);
                    bad += field_ok("position", e.position, i_m_axis_tdata[47:16]);
                    bad += field_ok("interval", e.interval, i_m_axis_tdata[79:48]);
                    bad += field_ok("channel", e.channel, i_m_axis_tdata[83:80]);
                    bad += field_ok("note_key", e.note_key, i_m_axis_tdata[90:84]);
                    bad += field_ok("velocity", e.velocity, i_m_axis_tdata[97:91]);
                    bad += field_ok("note_length", e.note_length, i_m_axis_tdata[129:98]);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                take_byte(i_s_axis_tuser, i_s_axis_tdata);
            if (bad != 0) o_fail_count <= o_fail_count + 1;
        end
        o_records_due <= due_records.size();
    end

endmodule

// File: sim/tb_midi_track_note_parser_core.sv
`timescale 1ns / 1ps

module tb_midi_track_note_parser_core;

    import mtnp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 3000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;    // [7:0] data_byte
    logic         s_tuser;    // [0] start_of_file
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;    // note record, see the port list of the block
    logic         m_tuser;    // [0] record_kind
    int           fail_count;
    int           records_due;

    // stream of file bytes, each with its start-of-file flag
    logic [7:0]   file_bytes[$];
    bit           file_starts[$];
    int           bytes_sent;
    int           cycle_cnt;

    midi_track_note_parser_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    mtnp_scoreboard i_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_records_due   (records_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void put(bit sof, logic [7:0] b);
        file_bytes.push_back(b);
        file_starts.push_back(sof);
    endfunction

    // header: ten skipped bytes, track count, timebase
    function automatic void put_header(logic [15:0] ntrk, logic [15:0] tbase);
        put(1'b1, 8'($urandom));
        for (int i = 1; i < 10; i++) put(1'b0, 8'($urandom));
        put(1'b0, ntrk[15:8]);
        put(1'b0, ntrk[7:0]);
        put(1'b0, tbase[15:8]);
        put(1'b0, tbase[7:0]);
    endfunction

    // one event as a byte list: variable-length delta, status, key, velocity
    function automatic void make_event(ref logic [7:0] ev[$], input bit big_deltas);
        int          r;
        logic [27:0] d;
        logic [3:0]  ch;
        ev.delete();
        r = $urandom_range(0, 99);
        if (big_deltas && r < 40) begin
            ev = '{8'hFF, 8'hFF, 8'hFF, 8'h7F};                 // largest proper delta
        end else if (r < 60) begin
            ev.push_back(8'($urandom_range(0, 20)));
        end else if (r < 80) begin
            d = 28'($urandom_range(128, 16383));
            ev = '{{1'b1, d[13:7]}, {1'b0, d[6:0]}};
        end else if (r < 92) begin
            d = 28'($urandom);
            ev = '{{1'b1, d[27:21]}, {1'b1, d[20:14]}, {1'b1, d[13:7]}, {1'b0, d[6:0]}};
        end else begin
            // long delta: bit 7 set on all four bytes
            for (int i = 0; i < 4; i++) ev.push_back(8'($urandom_range(128, 255)));
        end
        ch = 4'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 45) ev.push_back({KIND_ON, ch});
        else if (r < 82) ev.push_back({KIND_OFF, ch});
        else if (r < 92) ev.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                           : 8'($urandom_range(160, 255)));
        else ev.push_back(8'($urandom));
        // small key pool so note-offs find their notes; bit 7 of the key is noise
        ev.push_back({1'($urandom), 7'($urandom_range(60, 63))});
        ev.push_back(8'($urandom));
    endfunction

    // a track: tag, length, events; the length is sometimes wrong or zero
    function automatic void put_track(int n_events, bit big_deltas);
        logic [7:0]  body[$];
        logic [7:0]  ev[$];
        logic [31:0] len;
        int          r;
        for (int i = 0; i < 4; i++) put(1'b0, 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 6) n_events = 0;
        for (int i = 0; i < n_events; i++) begin
            make_event(ev, big_deltas);
            body = {body, ev};
        end
        len = body.size();
        if (r >= 6 && r < 16 && len > 2) len = len - $urandom_range(1, 2);   // overrun
        put(1'b0, len[31:24]);
        put(1'b0, len[23:16]);
        put(1'b0, len[15:8]);
        put(1'b0, len[7:0]);
        foreach (body[i]) put(1'b0, body[i]);
    endfunction

    // directed part: zero track count, then timebase zero with the event corner cases
    task automatic build_directed();
        put_header(16'd0, 16'd96);
        put(1'b0, 8'hFF);                          // ignored after the file ends
        put(1'b0, 8'h00);
        put_header(16'd1, 16'd0);
        put(1'b0, "M"); put(1'b0, "T"); put(1'b0, "r"); put(1'b0, "k");
        put(1'b0, 8'h00); put(1'b0, 8'h00); put(1'b0, 8'h00); put(1'b0, 8'd20);
        put(1'b0, 8'h00); put(1'b0, 8'h9F); put(1'b0, 8'hFF); put(1'b0, 8'h7F);  // on, key 127
        put(1'b0, 8'h05); put(1'b0, 8'h80); put(1'b0, 8'h00); put(1'b0, 8'h00);  // stray off
        put(1'b0, 8'h81); put(1'b0, 8'h8F); put(1'b0, 8'h7F); put(1'b0, 8'h00);  // 3-byte delta
        put(1'b0, 8'h00); put(1'b0, 8'hB0); put(1'b0, 8'h01); put(1'b0, 8'h02);  // other status
        put(1'b0, 8'h00); put(1'b0, 8'h90); put(1'b0, 8'h00); put(1'b0, 8'h00);  // no note-on
    endtask

    task automatic build_random();
        logic [15:0] tb_list[5];
        int          ntrk;
        tb_list = '{16'd1, 16'hFFFF, 16'd480, 16'd96, 16'd7};
        for (int f = 0; f < 7; f++) begin
            ntrk = $urandom_range(1, 3);
            put_header(16'(ntrk), (f < 5) ? tb_list[f] : 16'($urandom));
            for (int t = 0; t < ntrk; t++) put_track($urandom_range(2, 7), f == 2);
            if ($urandom_range(0, 1)) put(1'b0, 8'($urandom));   // trailing noise
        end
    endtask

    // sender
    initial begin
        int  g;
        bit  burst;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        bytes_sent = 0;
        i_rst_n = 1'b0;
        build_directed();
        build_random();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        burst = 1'b0;
        while (file_bytes.size() > 0) begin
            if (bytes_sent % 48 == 0) burst = ($urandom_range(0, 3) == 0);
            g = burst ? 0 : gap_len();
            if (g > 0) begin
                s_tvalid = 1'b0;
                repeat (g) @(negedge i_clk);
            end
            s_tvalid = 1'b1;
            s_tdata = file_bytes.pop_front();
            s_tuser = file_starts.pop_front();
            do @(posedge i_clk); while (!s_tready);
            bytes_sent++;
            @(negedge i_clk);
        end
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        while (records_due != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver, with one long hold-off partway through so the input side backs up
    initial begin
        int  g;
        int  hold;
        bit  held;
        m_tready = 1'b0;
        g = 0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && bytes_sent >= 260) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else if (g > 0) begin
                m_tready = 1'b0;
                g--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) g = gap_len();
            end
        end
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
